@@ rtl/core/dccpbg_pkg.sv @@
// Package for the DCC packet bit generator: sizes, codes, word layouts and structs.
// Shared by the register file, the framer and the top level; depends on nothing.
package dccpbg_pkg;

  localparam int MaxPacketBytes = 6;
  localparam int PacketLimit    = (MaxPacketBytes < 6) ? MaxPacketBytes : 6;
  localparam int PtrW           = $clog2(MaxPacketBytes);
  localparam int MsgBytes       = 6;

  localparam int InDataW  = 64;
  localparam int OutDataW = 24;
  localparam int OutUserW = 3;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  localparam logic [7:0] SERVICE_MASK = 8'h70;
  localparam logic [7:0] IDLE_BYTE0   = 8'hFF;
  localparam logic [7:0] IDLE_BYTE1   = 8'h00;

  localparam logic [5:0]  RST_PRE_LEN = 6'd20;
  localparam logic [15:0] RST_ZERO_HP = 16'd1392;
  localparam logic [15:0] RST_ONE_HP  = 16'd696;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PRE   = 6'b000010,
    ST_START = 6'b000100,
    ST_DATA  = 6'b001000,
    ST_XOR   = 6'b010000,
    ST_END   = 6'b100000
  } frame_state_t;

  typedef enum logic [2:0] {
    KIND_GAP   = 3'd0,
    KIND_PRE   = 3'd1,
    KIND_START = 3'd2,
    KIND_DATA  = 3'd3,
    KIND_XOR   = 3'd4,
    KIND_END   = 3'd5
  } bit_kind_t;

  typedef enum logic [1:0] {
    REG_PRE_LEN = 2'd0,
    REG_ZERO_HP = 2'd1,
    REG_ONE_HP  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [5:0]  pre_len;
    logic [15:0] zero_hp;
    logic [15:0] one_hp;
  } cfg_t;

  typedef struct packed {
    logic                     prog_on;
    logic                     msg_valid;
    logic [2:0]               msg_size;
    logic [7:0]               msg_repeats;
    logic [MsgBytes-1:0][7:0] msg_bytes;
  } in_item_t;

  typedef struct packed {
    logic        bit_value;
    logic [15:0] half_period;
    bit_kind_t   bit_kind;
    logic        msg_taken;
    logic        phase_update;
    logic        service_mode;
  } result_t;

  function automatic in_item_t unpack_item(input logic [InDataW-1:0] d);
    in_item_t it;
    it.prog_on     = d[0];
    it.msg_valid   = d[1];
    it.msg_size    = d[4:2];
    it.msg_repeats = d[12:5];
    for (int i = 0; i < MsgBytes; i++) begin
      it.msg_bytes[i] = d[13 + 8*i +: 8];
    end
    return it;
  endfunction

endpackage

@@ rtl/core/dccpbg_cfg_regs.sv @@
// Configuration register file of the DCC packet bit generator behind an APB-style port.
// Holds preamble length and both half periods; depends on dccpbg_pkg.
module dccpbg_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dccpbg_pkg::CfgAddrW-1:0] paddr,
  input  logic [dccpbg_pkg::CfgDataW-1:0] pwdata,
  output logic [dccpbg_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output dccpbg_pkg::cfg_t              cfg
);
  import dccpbg_pkg::*;

  logic [5:0]  pre_len_r;
  logic [15:0] zero_hp_r;
  logic [15:0] one_hp_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_len_r <= RST_PRE_LEN;
      zero_hp_r <= RST_ZERO_HP;
      one_hp_r  <= RST_ONE_HP;
    end else if (wr_en) begin
      unique case (idx)
        REG_PRE_LEN: pre_len_r <= pwdata[5:0];
        REG_ZERO_HP: zero_hp_r <= pwdata[15:0];
        REG_ONE_HP:  one_hp_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PRE_LEN: prdata = {26'd0, pre_len_r};
      REG_ZERO_HP: prdata = {16'd0, zero_hp_r};
      REG_ONE_HP:  prdata = {16'd0, one_hp_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg = {pre_len_r, zero_hp_r, one_hp_r};

endmodule

@@ rtl/core/dccpbg_framer.sv @@
// Framing machine of the DCC packet bit generator: packet store, counters and bit result.
// Advances once per accepted tick word; depends on dccpbg_pkg.
module dccpbg_framer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  dccpbg_pkg::in_item_t item,
  input  dccpbg_pkg::cfg_t     cfg,
  output dccpbg_pkg::result_t  res
);
  import dccpbg_pkg::*;

  frame_state_t    state_r, state_nxt;
  logic [7:0]      rep_cnt_r, rep_cnt_nxt;
  logic [5:0]      bits_left_r, bits_left_nxt;
  logic [2:0]      bytes_left_r, bytes_left_nxt;
  logic [PtrW-1:0] byte_ptr_r, byte_ptr_nxt;
  logic [7:0]      chk_r, chk_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic [2:0]      pkt_len_r, pkt_len_nxt;
  logic            last_bit_r;
  logic [7:0]      store_r [MaxPacketBytes];

  logic            load;
  logic            use_msg;
  logic [2:0]      size_clamp;
  logic [7:0]      rep_base;
  logic [7:0]      rd_byte;
  logic [15:0]     hp_raw;

  assign rd_byte    = store_r[byte_ptr_r];
  assign size_clamp = (item.msg_size > 3'(PacketLimit)) ? 3'(PacketLimit) : item.msg_size;

  always_comb begin
    state_nxt      = state_r;
    rep_cnt_nxt    = rep_cnt_r;
    bits_left_nxt  = bits_left_r;
    bytes_left_nxt = bytes_left_r;
    byte_ptr_nxt   = byte_ptr_r;
    chk_nxt        = chk_r;
    shift_nxt      = shift_r;
    pkt_len_nxt    = pkt_len_r;
    load           = 1'b0;
    use_msg        = 1'b0;
    rep_base       = rep_cnt_r;
    res.bit_value    = last_bit_r;
    res.bit_kind     = KIND_GAP;
    res.msg_taken    = 1'b0;
    res.phase_update = 1'b0;
    res.service_mode = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (rep_cnt_r == 8'd0) begin
          load = 1'b1;
          if (item.prog_on) begin
            res.phase_update = 1'b1;
            if (item.msg_valid) begin
              use_msg          = 1'b1;
              res.msg_taken    = 1'b1;
              res.service_mode = (item.msg_bytes[0] & SERVICE_MASK) == SERVICE_MASK;
            end
          end
          if (use_msg) begin
            pkt_len_nxt = size_clamp;
            rep_base    = (item.msg_repeats == 8'd0) ? 8'd1 : item.msg_repeats;
          end else begin
            pkt_len_nxt = 3'd2;
            rep_base    = 8'd1;
          end
        end
        rep_cnt_nxt    = rep_base - 8'd1;
        bytes_left_nxt = pkt_len_nxt;
        byte_ptr_nxt   = '0;
        chk_nxt        = 8'd0;
        bits_left_nxt  = (cfg.pre_len == 6'd0) ? 6'd1 : cfg.pre_len;
        state_nxt      = ST_PRE;
      end
      ST_PRE: begin
        res.bit_value = 1'b1;
        res.bit_kind  = KIND_PRE;
        bits_left_nxt = bits_left_r - 6'd1;
        if (bits_left_nxt == 6'd0) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        res.bit_value = 1'b0;
        res.bit_kind  = KIND_START;
        if (bytes_left_r == 3'd0) begin
          shift_nxt = chk_r;
          state_nxt = ST_XOR;
        end else begin
          bytes_left_nxt = bytes_left_r - 3'd1;
          shift_nxt      = rd_byte;
          byte_ptr_nxt   = byte_ptr_r + PtrW'(1);
          chk_nxt        = chk_r ^ rd_byte;
          state_nxt      = ST_DATA;
        end
        bits_left_nxt = 6'd8;
      end
      ST_DATA, ST_XOR: begin
        res.bit_value = shift_r[7];
        res.bit_kind  = (state_r == ST_DATA) ? KIND_DATA : KIND_XOR;
        shift_nxt     = {shift_r[6:0], 1'b0};
        bits_left_nxt = bits_left_r - 6'd1;
        if (bits_left_nxt == 6'd0) begin
          state_nxt = (state_r == ST_DATA) ? ST_START : ST_END;
        end
      end
      ST_END: begin
        res.bit_value = 1'b1;
        res.bit_kind  = KIND_END;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    hp_raw          = res.bit_value ? cfg.one_hp : cfg.zero_hp;
    res.half_period = (hp_raw == 16'd0) ? 16'd1 : hp_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rep_cnt_r    <= 8'd0;
      bits_left_r  <= 6'd0;
      bytes_left_r <= 3'd0;
      byte_ptr_r   <= '0;
      chk_r        <= 8'd0;
      shift_r      <= 8'd0;
      pkt_len_r    <= 3'd0;
      last_bit_r   <= 1'b1;
    end else if (advance) begin
      state_r      <= state_nxt;
      rep_cnt_r    <= rep_cnt_nxt;
      bits_left_r  <= bits_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      byte_ptr_r   <= byte_ptr_nxt;
      chk_r        <= chk_nxt;
      shift_r      <= shift_nxt;
      pkt_len_r    <= pkt_len_nxt;
      last_bit_r   <= res.bit_value;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      if (use_msg) begin
        for (int i = 0; i < PacketLimit; i++) begin
          if (3'(i) < size_clamp) begin
            store_r[i] <= item.msg_bytes[i];
          end
        end
      end else begin
        store_r[0] <= IDLE_BYTE0;
        store_r[1] <= IDLE_BYTE1;
      end
    end
  end

endmodule

@@ rtl/core/dcc_packet_bit_generator_unit.sv @@
// DCC packet bit generator: each tick word in yields one DCC bit word out, one word per cycle.
// The framer advances on every accepted tick and its result is held in an output register
// until taken. The block takes a new word every cycle while the output register is empty or
// being drained, so throughput is one bit slot per cycle. A packet is a preamble of ones,
// start bit plus eight data bits per byte MSB first, start bit, XOR checksum and a closing
// one, followed by one gap slot that repeats the last bit and, when no repeats remain, loads
// the next packet (queued packet if programming is on and one waits, else idle FF 00).
// Depends on dccpbg_pkg, dccpbg_cfg_regs and dccpbg_framer.
module dcc_packet_bit_generator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // prog_on, msg_valid, msg_size[3], msg_repeats[8], msg_byte0..msg_byte5[8 each], pad
  input  logic [dccpbg_pkg::InDataW-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // bit_value, half_period[16], msg_taken, phase_update, service_mode, pad
  output logic [dccpbg_pkg::OutDataW-1:0] out_tdata,
  // bit_kind[3]
  output logic [dccpbg_pkg::OutUserW-1:0] out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [dccpbg_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [dccpbg_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [dccpbg_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import dccpbg_pkg::*;

  cfg_t     cfg;
  in_item_t item;
  result_t  res;
  result_t  res_r;
  logic     out_valid_r;
  logic     accept;

  assign item      = unpack_item(in_tdata);
  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;

  dccpbg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dccpbg_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .item    (item),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.service_mode, res_r.phase_update, res_r.msg_taken,
                       res_r.half_period, res_r.bit_value};
  assign out_tuser  = res_r.bit_kind;

endmodule

@@ verif/tb_dcc_packet_bit_generator_unit.sv @@
// Self-checking bench for dcc_packet_bit_generator_unit: drives tick words with queued packets,
// predicts every DCC bit word in step with accepted ticks and checks results field by field.
// Depends on dccpbg_pkg and the RTL under rtl/core.
module tb_dcc_packet_bit_generator_unit;
  import dccpbg_pkg::*;

  localparam int StallLimit = 4000;
  localparam int TargetTicks = 950;
  localparam int RandomPhases = 3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [OutDataW-1:0] out_tdata;
  logic [OutUserW-1:0] out_tuser;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [CfgDataW-1:0] cfg_pwdata = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  dcc_packet_bit_generator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // framer model state
  frame_state_t fr_state = ST_IDLE;
  logic [7:0]   rep_left = '0;
  logic [5:0]   bits_left = '0;
  logic [2:0]   bytes_left = '0;
  logic [2:0]   byte_ptr = '0;
  logic [7:0]   csum = '0;
  logic [7:0]   shreg = '0;
  logic [7:0]   pkt_bytes [0:7];
  logic [2:0]   pkt_len = '0;
  logic         prev_bit = 1'b1;
  logic [5:0]   pre_len = RST_PRE_LEN;
  logic [15:0]  zero_hp = RST_ZERO_HP;
  logic [15:0]  one_hp = RST_ONE_HP;

  result_t expected_bits [$];
  int  n_errors = 0;
  int  n_ticks = 0;
  int  n_results = 0;
  int  n_taken = 0;
  int  n_service = 0;
  int  n_writes = 0;
  int  idle_cycles = 0;
  int  rx_hold = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] half_of(logic b);
    logic [15:0] p;
    p = b ? one_hp : zero_hp;
    return (p == 16'd0) ? 16'd1 : p;
  endfunction

  function automatic result_t predict_slot(in_item_t it);
    result_t r;
    logic    b;
    logic    use_msg;
    int      sz;
    r = '0;
    r.bit_kind = KIND_GAP;
    b = prev_bit;
    case (fr_state)
      ST_IDLE: begin
        if (rep_left == 8'd0) begin
          use_msg = 1'b0;
          if (it.prog_on) begin
            r.phase_update = 1'b1;
            if (it.msg_valid) begin
              use_msg = 1'b1;
              r.msg_taken = 1'b1;
              r.service_mode = ((it.msg_bytes[0] & SERVICE_MASK) == SERVICE_MASK);
            end
          end
          if (use_msg) begin
            sz = (it.msg_size > PacketLimit) ? PacketLimit : int'(it.msg_size);
            for (int i = 0; i < sz; i++) pkt_bytes[i] = it.msg_bytes[i];
            pkt_len = 3'(sz);
            rep_left = (it.msg_repeats == 8'd0) ? 8'd1 : it.msg_repeats;
          end else begin
            pkt_bytes[0] = IDLE_BYTE0;
            pkt_bytes[1] = IDLE_BYTE1;
            pkt_len = 3'd2;
            rep_left = 8'd1;
          end
        end
        rep_left = rep_left - 8'd1;
        bytes_left = pkt_len;
        byte_ptr = '0;
        csum = '0;
        bits_left = (pre_len == 6'd0) ? 6'd1 : pre_len;
        fr_state = ST_PRE;
      end
      ST_PRE: begin
        b = 1'b1;
        r.bit_kind = KIND_PRE;
        bits_left = bits_left - 6'd1;
        if (bits_left == 6'd0) fr_state = ST_START;
      end
      ST_START: begin
        b = 1'b0;
        r.bit_kind = KIND_START;
        if (bytes_left == 3'd0) begin
          shreg = csum;
          fr_state = ST_XOR;
        end else begin
          bytes_left = bytes_left - 3'd1;
          shreg = pkt_bytes[byte_ptr];
          byte_ptr = byte_ptr + 3'd1;
          csum = csum ^ shreg;
          fr_state = ST_DATA;
        end
        bits_left = 6'd8;
      end
      ST_DATA, ST_XOR: begin
        b = shreg[7];
        r.bit_kind = (fr_state == ST_DATA) ? KIND_DATA : KIND_XOR;
        shreg = shreg << 1;
        bits_left = bits_left - 6'd1;
        if (bits_left == 6'd0) fr_state = (fr_state == ST_DATA) ? ST_START : ST_END;
      end
      ST_END: begin
        b = 1'b1;
        r.bit_kind = KIND_END;
        fr_state = ST_IDLE;
      end
      default: fr_state = ST_IDLE;
    endcase
    prev_bit = b;
    r.bit_value = b;
    r.half_period = half_of(b);
    return r;
  endfunction

  function automatic bit at_take_point();
    return fr_state == ST_IDLE && rep_left == 8'd0;
  endfunction

  task automatic send_word(in_item_t it);
    int      gap;
    result_t r;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {3'b000, it.msg_bytes, it.msg_repeats, it.msg_size, it.msg_valid, it.prog_on};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    n_ticks++;
    r = predict_slot(it);
    if (r.msg_taken) n_taken++;
    if (r.service_mode) n_service++;
    expected_bits.push_back(r);
  endtask

  function automatic in_item_t noise_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return in_item_t'(w[60:0]);
  endfunction

  function automatic in_item_t make_msg(logic [2:0] size, logic [7:0] reps, logic [7:0] b0);
    in_item_t it;
    it = noise_word();
    it.prog_on = 1'b1;
    it.msg_valid = 1'b1;
    it.msg_size = size;
    it.msg_repeats = reps;
    it.msg_bytes[0] = b0;
    return it;
  endfunction

  function automatic in_item_t random_msg();
    in_item_t it;
    int       r;
    it = noise_word();
    it.prog_on = ($urandom_range(0, 9) != 0);
    it.msg_valid = ($urandom_range(0, 4) != 0);
    it.msg_size = ($urandom_range(0, 9) < 6) ? 3'($urandom_range(1, 3)) : 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 50) it.msg_repeats = 8'd0;
    else if (r < 80) it.msg_repeats = 8'd1;
    else if (r < 98) it.msg_repeats = 8'($urandom_range(2, 4));
    else it.msg_repeats = 8'($urandom_range(5, 8));
    if ($urandom_range(0, 2) == 0) it.msg_bytes[0][6:4] = 3'b111;
    return it;
  endfunction

  task automatic send_packet(in_item_t it);
    while (!at_take_point()) send_word(noise_word());
    send_word(it);
  endtask

  task automatic finish_frames();
    while (!at_take_point()) send_word(noise_word());
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CfgAddrW'(4 * int'(idx));
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_PRE_LEN: pre_len = val[5:0];
      REG_ZERO_HP: zero_hp = val[15:0];
      REG_ONE_HP:  one_hp = val[15:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_config(logic [5:0] pre, logic [15:0] zhp, logic [15:0] ohp);
    drain_results();
    write_reg(REG_PRE_LEN, {26'd0, pre});
    write_reg(REG_ZERO_HP, {16'd0, zhp});
    write_reg(REG_ONE_HP, {16'd0, ohp});
  endtask

  task automatic test_idle_packets();
    in_item_t it;
    it = noise_word();
    it.prog_on = 1'b0;
    send_packet(it);
    it = noise_word();
    it.prog_on = 1'b1;
    it.msg_valid = 1'b0;
    send_packet(it);
  endtask

  task automatic test_service_report();
    set_config(6'd1, RST_ZERO_HP, RST_ONE_HP);
    send_packet(make_msg(3'd1, 8'd0, 8'h70));
    send_packet(make_msg(3'd2, 8'd1, 8'h6F));
    send_packet(make_msg(3'd1, 8'd1, 8'hF0));
    send_packet(make_msg(3'd3, 8'd1, 8'h00));
  endtask

  task automatic test_packet_sizes();
    in_item_t it;
    it = make_msg(3'd6, 8'd1, 8'h7F);
    it.msg_bytes[1] = 8'hFF;
    it.msg_bytes[5] = 8'h00;
    send_packet(it);
    send_packet(make_msg(3'd7, 8'd1, 8'hFF));
    send_packet(make_msg(3'd0, 8'd1, 8'h00));
    send_packet(make_msg(3'd0, 8'd0, 8'h77));
    finish_frames();
  endtask

  task automatic test_register_extremes();
    set_config(6'd0, 16'd0, 16'd0);
    send_packet(make_msg(3'd1, 8'd1, 8'hA5));
    finish_frames();
    set_config(6'd63, 16'hFFFF, 16'hFFFF);
    send_packet(make_msg(3'd2, 8'd1, 8'h5A));
    finish_frames();
    set_config(6'd1, 16'd1, 16'hFFFF);
    send_packet(make_msg(3'd1, 8'd0, 8'h3C));
    finish_frames();
  endtask

  task automatic test_long_repeat();
    send_packet(make_msg(3'd0, 8'd10, 8'h75));
    finish_frames();
  endtask

  task automatic test_backpressure();
    set_config(6'd2, 16'd100, 16'd50);
    rx_hold = 300;
    tx_idle_on = 1'b0;
    repeat (2) send_packet(random_msg());
    tx_idle_on = 1'b1;
    drain_results();
    send_packet(random_msg());
  endtask

  task automatic test_random_traffic();
    int ph_end;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      set_config(6'($urandom_range(1, 12)), 16'($urandom_range(1, 65535)),
                 16'($urandom_range(1, 65535)));
      ph_end = n_ticks + (TargetTicks - n_ticks) / (RandomPhases - ph);
      while (n_ticks < ph_end) begin
        if ($urandom_range(0, 15) == 0) tx_idle_on = !tx_idle_on;
        send_packet(random_msg());
      end
    end
    finish_frames();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_packets();
    test_service_report();
    test_packet_sizes();
    test_register_extremes();
    test_long_repeat();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d tick words, %0d bit words checked, %0d packets taken (%0d service mode),",
             n_ticks, n_results, n_taken, n_service);
    $display("%0d register writes across reset, extreme and random timing settings", n_writes);
    if (n_errors == 0) begin
      $display("tb_dcc_packet_bit_generator_unit: clean");
    end else begin
      $display("tb_dcc_packet_bit_generator_unit: errors");
    end
    $finish;
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      stall = rx_idle_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if ($urandom_range(0, 63) == 0) rx_idle_on = !rx_idle_on;
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_bits.size() == 0) begin
        $error("bit word 0x%h kind %0d arrived with nothing expected", out_tdata, out_tuser);
        n_errors++;
      end else begin
        want = expected_bits.pop_front();
        check_field("bit_value", 16'(want.bit_value), 16'(out_tdata[0]));
        check_field("half_period", want.half_period, out_tdata[16:1]);
        check_field("bit_kind", 16'(want.bit_kind), 16'(out_tuser));
        check_field("msg_taken", 16'(want.msg_taken), 16'(out_tdata[17]));
        check_field("phase_update", 16'(want.phase_update), 16'(out_tdata[18]));
        check_field("service_mode", 16'(want.service_mode), 16'(out_tdata[19]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("no word moved for %0d cycles, %0d bit words outstanding",
               idle_cycles, expected_bits.size());
      $display("tb_dcc_packet_bit_generator_unit: errors");
      $finish;
    end
  end

endmodule
